### hdl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types and constants of the Sv32 page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int XLEN      = 32;
  localparam int PPN_W     = 22;
  localparam int LEN_W     = 3;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int IN_DATA_W = 104;
  localparam int OUT_DATA_W = 72;

  // Bit positions of R and X in a page table entry.
  localparam int PTE_R_BIT = 1;
  localparam int PTE_X_BIT = 3;

  // Table entry fetches are always one word.
  localparam logic [LEN_W-1:0] FETCH_LEN = 3'd4;

  // Register select, taken from address bit 2.
  localparam logic REG_ROOT_PPN  = 1'b0;
  localparam logic REG_TRANSLATE = 1'b1;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_PTE   = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_FETCH  = 2'd0,
    KIND_ACCESS = 2'd1,
    KIND_FAULT  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_PTE   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_L1   = 2'd1,
    PH_L0   = 2'd2
  } phase_t;

  // One classified item. word holds the virtual address of a request or
  // the returned table entry.
  typedef struct packed {
    op_t              op;
    logic [XLEN-1:0]  word;
    logic [XLEN-1:0]  wdata;
    logic [LEN_W-1:0] len;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

### hdl/sv32_page_table_walker_core.sv
// ----------------------------------------------------------------------------
// sv32_page_table_walker_core
// Two-level Sv32 page table walker with bare-address bypass.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  in_      slave      tuser: action; tdata: vaddr, write_data, access_len,
//                      entry_data
//  out_     master     tuser: kind; tdata: address, is_write, store_data,
//                      size_bytes
//  cfg_     APB slave  0x0 root_ppn, 0x4 translate_enable
//
// One item per cycle is sustained while the sink is ready. An item's result is
// written into a queue slot and then into the result register before it is
// presented to the sink.
// A two-entry queue keeps input taking items while the result register waits.
// Synchronous active-low reset empties the queue and returns the walk to idle.
// ----------------------------------------------------------------------------
module sv32_page_table_walker_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] vaddr, [63:32] write_data, [66:64] access_len, [98:67] entry_data
  input  logic [ptw_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] action
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] address, [32] is_write, [64:33] store_data, [67:65] size_bytes
  output logic [ptw_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [1:0] kind
  output logic [1:0]                      out_tuser,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [ptw_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [ptw_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [ptw_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                            cfg_pready
);

  logic [ptw_pkg::PPN_W-1:0] root_ppn_r, root_ppn_nxt;
  logic                      translate_r, translate_nxt;
  logic                      cfg_wr;

  ptw_pkg::q_stat_t  q_stat;
  ptw_pkg::q_entry_t push_entry;
  ptw_pkg::q_entry_t pop_entry;
  logic              push;
  logic              pop;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    root_ppn_nxt  = root_ppn_r;
    translate_nxt = translate_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        ptw_pkg::REG_ROOT_PPN:  root_ppn_nxt  = cfg_pwdata[ptw_pkg::PPN_W-1:0];
        ptw_pkg::REG_TRANSLATE: translate_nxt = cfg_pwdata[0];
        default:                root_ppn_nxt  = root_ppn_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      ptw_pkg::REG_ROOT_PPN:  cfg_prdata = {10'd0, root_ppn_r};
      ptw_pkg::REG_TRANSLATE: cfg_prdata = {31'd0, translate_r};
      default:                cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_ppn_r  <= '0;
      translate_r <= 1'b0;
    end else begin
      root_ppn_r  <= root_ppn_nxt;
      translate_r <= translate_nxt;
    end
  end

  ptw_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  ptw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_stat     (q_stat)
  );

  ptw_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .root_ppn         (root_ppn_r),
    .translate_enable (translate_r),
    .q_stat           (q_stat),
    .q_entry          (pop_entry),
    .pop              (pop),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser)
  );

endmodule

### hdl/ptw_front.sv
// ----------------------------------------------------------------------------
// ptw_front
// Accepts input items, classifies them and pushes them into the queue.
// ----------------------------------------------------------------------------
module ptw_front (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ptw_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                     in_tuser,
  input  ptw_pkg::q_stat_t               q_stat,
  output logic                           push,
  output ptw_pkg::q_entry_t              push_entry
);

  logic          accept;
  logic          keep;
  ptw_pkg::op_t  op;
  logic [31:0]   vaddr;
  logic [31:0]   wdata;
  logic [2:0]    len;
  logic [31:0]   pte;

  assign vaddr = in_tdata[31:0];
  assign wdata = in_tdata[63:32];
  assign len   = in_tdata[66:64];
  assign pte   = in_tdata[98:67];

  assign in_tready = ~q_stat.full;
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    keep = 1'b1;
    op   = ptw_pkg::OP_READ;
    unique case (ptw_pkg::action_t'(in_tuser))
      ptw_pkg::ACT_READ:  op = ptw_pkg::OP_READ;
      ptw_pkg::ACT_WRITE: op = ptw_pkg::OP_WRITE;
      ptw_pkg::ACT_PTE:   op = ptw_pkg::OP_PTE;
      default:            keep = 1'b0;
    endcase
  end

  // An undefined action is taken and dropped here.
  assign push             = accept & keep;
  assign push_entry.op    = op;
  assign push_entry.word  = (op == ptw_pkg::OP_PTE) ? pte : vaddr;
  assign push_entry.wdata = wdata;
  assign push_entry.len   = len;

endmodule

### hdl/ptw_queue.sv
// ----------------------------------------------------------------------------
// ptw_queue
// Two-entry queue between the classifying front and the walking back.
// ----------------------------------------------------------------------------
module ptw_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ptw_pkg::q_entry_t   push_entry,
  input  logic                pop,
  output ptw_pkg::q_entry_t   pop_entry,
  output ptw_pkg::q_stat_t    q_stat
);

  ptw_pkg::q_entry_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.valid = (count_r != 2'd0);
  assign pop_entry    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### hdl/ptw_back.sv
// ----------------------------------------------------------------------------
// ptw_back
// Walk engine: holds the pending request and the walk phase, and drives
// the result register.
// ----------------------------------------------------------------------------
module ptw_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [ptw_pkg::PPN_W-1:0]       root_ppn,
  input  logic                            translate_enable,
  input  ptw_pkg::q_stat_t                q_stat,
  input  ptw_pkg::q_entry_t               q_entry,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ptw_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [1:0]                      out_tuser
);

  ptw_pkg::phase_t phase_r, phase_nxt;
  logic [31:0]     held_vaddr_r;
  logic            held_is_write_r;
  logic [31:0]     held_data_r;
  logic [2:0]      held_len_r;

  logic            out_valid_r, out_valid_nxt;
  ptw_pkg::kind_t  out_kind_r;
  logic [31:0]     out_addr_r;
  logic            out_wr_r;
  logic [31:0]     out_data_r;
  logic [2:0]      out_len_r;

  logic            res_valid;
  ptw_pkg::kind_t  res_kind;
  logic [31:0]     res_addr;
  logic            res_wr;
  logic [31:0]     res_data;
  logic [2:0]      res_len;

  logic            is_req;
  logic            req_wr;
  logic            pte_leaf;
  logic            start_walk;
  logic [31:0]     w;

  assign pop        = q_stat.valid & (~out_valid_r | out_tready);
  assign w          = q_entry.word;
  assign is_req     = (q_entry.op == ptw_pkg::OP_READ) | (q_entry.op == ptw_pkg::OP_WRITE);
  assign req_wr     = (q_entry.op == ptw_pkg::OP_WRITE);
  assign pte_leaf   = w[ptw_pkg::PTE_R_BIT] | w[ptw_pkg::PTE_X_BIT];
  assign start_walk = pop & is_req & translate_enable;

  // Next walk phase. A new request restarts the walk when translation is enabled.
  always_comb begin
    phase_nxt = phase_r;
    if (pop) begin
      if (is_req) begin
        if (translate_enable) begin
          phase_nxt = ptw_pkg::PH_L1;
        end
      end else if (q_entry.op == ptw_pkg::OP_PTE) begin
        unique case (phase_r)
          ptw_pkg::PH_L1: phase_nxt = pte_leaf ? ptw_pkg::PH_IDLE : ptw_pkg::PH_L0;
          ptw_pkg::PH_L0: phase_nxt = ptw_pkg::PH_IDLE;
          default:        phase_nxt = phase_r;
        endcase
      end
    end
  end

  // Result of the item leaving the queue.
  always_comb begin
    res_valid = 1'b0;
    res_kind  = ptw_pkg::KIND_FETCH;
    res_addr  = '0;
    res_wr    = 1'b0;
    res_data  = '0;
    res_len   = ptw_pkg::FETCH_LEN;
    if (pop) begin
      if (is_req) begin
        res_valid = 1'b1;
        if (!translate_enable) begin
          res_kind = ptw_pkg::KIND_ACCESS;
          res_addr = w;
          res_wr   = req_wr;
          res_data = req_wr ? q_entry.wdata : '0;
          res_len  = q_entry.len;
        end else begin
          // Level-1 entry sits at root page plus VPN1 times four.
          res_addr = {root_ppn[19:0], w[31:22], 2'b00};
        end
      end else if (q_entry.op == ptw_pkg::OP_PTE) begin
        unique case (phase_r)
          ptw_pkg::PH_L1: begin
            res_valid = 1'b1;
            if (pte_leaf) begin
              res_kind = ptw_pkg::KIND_ACCESS;
              res_addr = {w[29:20], held_vaddr_r[21:0]};
              res_wr   = held_is_write_r;
              res_data = held_is_write_r ? held_data_r : '0;
              res_len  = held_len_r;
            end else begin
              res_addr = {w[29:10], held_vaddr_r[21:12], 2'b00};
            end
          end
          ptw_pkg::PH_L0: begin
            res_valid = 1'b1;
            res_wr    = held_is_write_r;
            res_len   = held_len_r;
            if (pte_leaf) begin
              res_kind = ptw_pkg::KIND_ACCESS;
              res_addr = {w[29:10], held_vaddr_r[11:0]};
              res_data = held_is_write_r ? held_data_r : '0;
            end else begin
              res_kind = ptw_pkg::KIND_FAULT;
              res_addr = held_vaddr_r;
            end
          end
          default: res_valid = 1'b0;
        endcase
      end
    end
  end

  always_comb begin
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ptw_pkg::PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start_walk) begin
      held_vaddr_r    <= w;
      held_is_write_r <= req_wr;
      held_data_r     <= q_entry.wdata;
      held_len_r      <= q_entry.len;
    end
    if (res_valid) begin
      out_kind_r <= res_kind;
      out_addr_r <= res_addr;
      out_wr_r   <= res_wr;
      out_data_r <= res_data;
      out_len_r  <= res_len;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {4'b0000, out_len_r, out_data_r, out_wr_r, out_addr_r};

endmodule
